// ===== rtl/core/sm3_pkg.sv =====
// sm3 hash package: payload types, constants and bit helpers
package sm3_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } sm3_out_t;

  typedef logic [7:0][31:0] sm3_word8_t;

  // schedule window taps used by one round
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w3;
    logic [31:0] w4;
    logic [31:0] w7;
    logic [31:0] w10;
    logic [31:0] w13;
  } sm3_taps_t;

  localparam logic [31:0] SM3_T_LOW  = 32'h79cc4519;
  localparam logic [31:0] SM3_T_HIGH = 32'h7a879d8a;
  localparam logic [31:0] SM3_PAD_WORD = 32'h80000000;
  localparam logic [5:0]  SM3_LAST_ROUND = 6'd63;
  localparam logic [3:0]  SM3_LEN_HI_SLOT = 4'd14;
  localparam logic [3:0]  SM3_LAST_SLOT = 4'd15;
  localparam logic [2:0]  SM3_LAST_INDEX = 3'd7;
  localparam logic [2:0]  SM3_FULL_BYTES = 3'd4;

  localparam sm3_word8_t SM3_IV = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_OUT  = 4'b1000
  } sm3_state_e;

  function automatic logic [31:0] sm3_rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] sm3_p0(input logic [31:0] x);
    return x ^ sm3_rotl(x, 5'd9) ^ sm3_rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] sm3_p1(input logic [31:0] x);
    return x ^ sm3_rotl(x, 5'd15) ^ sm3_rotl(x, 5'd23);
  endfunction

endpackage

// ===== rtl/core/sm3_round.sv =====
// sm3 round unit: one compression round and one schedule word
module sm3_round import sm3_pkg::*; (
  input  sm3_word8_t  regs_i,
  input  sm3_taps_t   taps_i,
  input  logic [5:0]  round_i,
  output sm3_word8_t  regs_o,
  output logic [31:0] w_new_o
);

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] t_const, ff, gg, a12, s1, s2, t1, t2;
  logic        early;

  assign {h, g, f, e, d, c, b, a} = regs_i;
  assign early = (round_i[5:4] == 2'b00);
  assign t_const = early ? SM3_T_LOW : SM3_T_HIGH;

  always_comb begin
    if (early) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
  end

  assign a12 = sm3_rotl(a, 5'd12);
  assign s1  = sm3_rotl(a12 + e + sm3_rotl(t_const, round_i[4:0]), 5'd7);
  assign s2  = s1 ^ a12;
  assign t1  = ff + d + s2 + (taps_i.w0 ^ taps_i.w4);
  assign t2  = gg + h + s1 + taps_i.w0;

  assign regs_o = {g, sm3_rotl(f, 5'd19), e, sm3_p0(t2),
                   c, sm3_rotl(b, 5'd9), a, t1};

  // w[j+16] from the rolling window
  assign w_new_o = sm3_p1(taps_i.w0 ^ taps_i.w7 ^ sm3_rotl(taps_i.w13, 5'd15))
                 ^ sm3_rotl(taps_i.w3, 5'd7) ^ taps_i.w10;

endmodule

// ===== rtl/core/sm3_hash.sv =====
// sm3 hash top level: message intake, padding, round sequencer, digest output
//
// usage
//   input channel (in_valid_i / in_ready_o / in_data_i) takes one big-endian
//   32-bit message word per transaction with a valid byte count and a last flag
//   output channel (out_valid_o / out_ready_i / out_data_o) returns the 256-bit
//   digest as eight transactions, word 0 (most significant) first
// timing
//   a plain word is taken while the sequencer is idle; every 16th word
//   starts a compression on the shared round unit, during which no input
//   is taken; after a last word the sequencer pushes padding one word per
//   cycle while not compressing (up to 18 words) and may run one or two
//   compressions, then the digest is shown
//   in_ready_o is high only while the sequencer is idle
// reset and stall
//   reset loads the initial vector and clears the length, counters and flags
//   a stalled receiver holds the current digest word; the block takes no
//   input until the eighth word is taken, then reloads the initial vector
module sm3_hash import sm3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sm3_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sm3_out_t out_data_o
);

  sm3_state_e  state_q, state_d;
  sm3_word8_t  chain_q, chain_d;
  sm3_word8_t  work_q, work_d;
  logic [15:0][31:0] win_q, win_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;
  logic        pad_q, pad_d;       // padding of the current message in progress
  logic        need80_q, need80_d; // separate 0x80 word still owed
  logic        hi_q, hi_d;         // high length word already pushed
  logic        fin_q, fin_d;       // low length word pushed, digest follows

  sm3_word8_t  rnd_regs;
  logic [31:0] rnd_wnew;
  sm3_taps_t   taps;

  logic        push;
  logic [31:0] push_w;
  logic [2:0]  nbytes;
  logic [31:0] keep_mask, pad_bit;

  // fixed window taps: slot 0 always holds w[j]
  assign taps = '{w0: win_q[0], w3: win_q[3], w4: win_q[4], w7: win_q[7],
                  w10: win_q[10], w13: win_q[13]};

  sm3_round u_round (
    .regs_i  (work_q),
    .taps_i  (taps),
    .round_i (round_q),
    .regs_o  (rnd_regs),
    .w_new_o (rnd_wnew)
  );

  // byte count clamp and last-word masks
  assign nbytes = (in_data_i.valid_bytes > SM3_FULL_BYTES) ? SM3_FULL_BYTES
                                                           : in_data_i.valid_bytes;
  always_comb begin
    unique case (nbytes)
      3'd0:    begin keep_mask = 32'h00000000; pad_bit = 32'h80000000; end
      3'd1:    begin keep_mask = 32'hff000000; pad_bit = 32'h00800000; end
      3'd2:    begin keep_mask = 32'hffff0000; pad_bit = 32'h00008000; end
      3'd3:    begin keep_mask = 32'hffffff00; pad_bit = 32'h00000080; end
      default: begin keep_mask = 32'hffffffff; pad_bit = 32'h00000000; end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    chain_d  = chain_q;
    work_d   = work_q;
    win_d    = win_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    round_d  = round_q;
    idx_d    = idx_q;
    pad_d    = pad_q;
    need80_d = need80_q;
    hi_d     = hi_q;
    fin_d    = fin_q;
    push     = 1'b0;
    push_w   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          push = 1'b1;
          if (!in_data_i.last_word) begin
            len_d  = len_q + 64'd32;
            push_w = in_data_i.data_word;
          end else begin
            len_d    = len_q + {58'd0, nbytes, 3'd0};
            push_w   = (in_data_i.data_word & keep_mask) | pad_bit;
            pad_d    = 1'b1;
            need80_d = (nbytes == SM3_FULL_BYTES);
            state_d  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        if (need80_q) begin
          push_w   = SM3_PAD_WORD;
          need80_d = 1'b0;
        end else if (hi_q) begin
          push_w = len_q[31:0];
          hi_d   = 1'b0;
          fin_d  = 1'b1;
        end else if (cnt_q == SM3_LEN_HI_SLOT) begin
          push_w = len_q[63:32];
          hi_d   = 1'b1;
        end else begin
          push_w = '0;
        end
      end
      ST_COMP: begin
        work_d = rnd_regs;
        win_d  = {rnd_wnew, win_q[15:1]};
        round_d = round_q + 6'd1;
        if (round_q == SM3_LAST_ROUND) begin
          chain_d = chain_q ^ rnd_regs;
          round_d = '0;
          if (fin_q) begin
            state_d = ST_OUT;
          end else if (pad_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (idx_q == SM3_LAST_INDEX) begin
            chain_d = SM3_IV;
            len_d   = '0;
            cnt_d   = '0;
            idx_d   = '0;
            pad_d   = 1'b0;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a push shifts the window; the sixteenth word starts compression
    if (push) begin
      win_d = {push_w, win_q[15:1]};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == SM3_LAST_SLOT) begin
        work_d  = chain_q;
        state_d = ST_COMP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chain_q  <= SM3_IV;
      cnt_q    <= '0;
      len_q    <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      pad_q    <= 1'b0;
      need80_q <= 1'b0;
      hi_q     <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      chain_q  <= chain_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      pad_q    <= pad_d;
      need80_q <= need80_d;
      hi_q     <= hi_d;
      fin_q    <= fin_d;
    end
  end

  // working registers and window are payload, fully loaded before use
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    win_q  <= win_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = '{digest_word: chain_q[idx_q],
                         word_index:  idx_q,
                         digest_last: (idx_q == SM3_LAST_INDEX)};

  // round counter only moves during compression
  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_COMP) |-> (round_q == 6'd0))
    else $error("round counter nonzero outside compression");

  // compression runs until the last round
  a_comp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && round_q != SM3_LAST_ROUND) |=> (state_q == ST_COMP))
    else $error("compression left early");

  // digest is only shown once the length words are in
  a_out_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fin_q && pad_q && cnt_q == 4'd0))
    else $error("digest shown before padding finished");

  // the block never takes input while a digest is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest pending");

endmodule
